### design/cpf_check_digit_validator_macros.svh
`ifndef CPF_CHECK_DIGIT_VALIDATOR_MACROS_SVH
`define CPF_CHECK_DIGIT_VALIDATOR_MACROS_SVH

// same-cycle implication, off while in reset
`define CPF_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("cpf check failed");

// next-cycle implication, off while in reset
`define CPF_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("cpf check failed");

`endif

### design/cpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

    localparam logic [3:0] POS_DOT1   = 4'd3;
    localparam logic [3:0] POS_DOT2   = 4'd7;
    localparam logic [3:0] POS_DASH   = 4'd11;
    localparam logic [3:0] POS_CHECK1 = 4'd12;
    localparam logic [3:0] POS_LAST   = 4'd13;
    localparam logic [3:0] POS_MAX    = 4'd15;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_LAYOUT = 2'd2;
    localparam logic [1:0] ERR_CHECK  = 2'd3;

    // sums are kept reduced mod 11, which is all the check values need
    typedef struct packed {
        logic [3:0] pos;
        logic       layout_ok;
        logic [3:0] first_sum;
        logic [3:0] second_sum;
        logic [3:0] first_check;
    } cpf_state_t;

    typedef struct packed {
        logic       cpf_valid;
        logic [1:0] error_kind;
    } cpf_verdict_t;

    localparam cpf_state_t STATE_RESET = '{4'd0, 1'b1, 4'd0, 4'd0, 4'd0};

    // weights for the first sum, already reduced mod 11
    function automatic logic [3:0] weight_first(input logic [3:0] pos);
        logic [3:0] w;
        begin
            case (pos)
                4'd0:    w = 4'd10;
                4'd1:    w = 4'd9;
                4'd2:    w = 4'd8;
                4'd4:    w = 4'd7;
                4'd5:    w = 4'd6;
                4'd6:    w = 4'd5;
                4'd8:    w = 4'd4;
                4'd9:    w = 4'd3;
                4'd10:   w = 4'd2;
                default: w = 4'd0;
            endcase
            return w;
        end
    endfunction

    // weights for the second sum mod 11 (weight 11 folds to 0)
    function automatic logic [3:0] weight_second(input logic [3:0] pos);
        logic [3:0] w;
        begin
            case (pos)
                4'd1:    w = 4'd10;
                4'd2:    w = 4'd9;
                4'd4:    w = 4'd8;
                4'd5:    w = 4'd7;
                4'd6:    w = 4'd6;
                4'd8:    w = 4'd5;
                4'd9:    w = 4'd4;
                4'd10:   w = 4'd3;
                4'd12:   w = 4'd2;
                default: w = 4'd0;
            endcase
            return w;
        end
    endfunction

    // x mod 11 for x < 128: quotient by reciprocal 187/2048, exact in this range
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] m;
        logic [3:0]  q;
        logic [7:0]  qx;
        logic [6:0]  r;
        begin
            m  = {8'd0, x} * 15'd187;
            q  = m[14:11];
            qx = {4'd0, q} * 8'd11;
            r  = x - qx[6:0];
            return r[3:0];
        end
    endfunction

    // (s * 10) mod 11 is (11 - s) mod 11; a value of 10 maps to 0
    function automatic logic [3:0] check_value(input logic [3:0] s);
        logic [3:0] v;
        begin
            if (s == 4'd0 || s == 4'd1)
                v = 4'd0;
            else
                v = 4'd11 - s;
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### design/cpf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cpf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cpf_verdict_if;
    logic       valid;
    logic       ready;
    logic       cpf_valid;
    logic [1:0] error_kind;

    modport source (output valid, output cpf_valid, output error_kind, input ready);
    modport sink   (input valid, input cpf_valid, input error_kind, output ready);
endinterface

`default_nettype wire

### design/cpf_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_step
    import cpf_pkg::*;
(
    input  wire cpf_state_t   cur,
    input  wire logic [7:0]   char_code,
    input  wire logic         last_char,
    output cpf_state_t        nxt,
    output cpf_verdict_t      verdict
);

    logic       is_digit;
    logic [3:0] d;
    logic       fits;
    logic       in_range;
    logic [7:0] prod_first;
    logic [7:0] prod_second;
    logic [7:0] tot_first;
    logic [7:0] tot_second;
    cpf_state_t upd;
    logic [1:0] err;

    always_comb
    begin
        is_digit = char_code inside {[CHAR_ZERO:CHAR_NINE]};
        d        = is_digit ? char_code[3:0] : 4'd0;
        in_range = cur.pos inside {[4'd0:POS_LAST]};

        case (cur.pos)
            POS_DOT1, POS_DOT2: fits = (char_code == CHAR_DOT);
            POS_DASH:           fits = (char_code == CHAR_DASH);
            default:            fits = in_range ? is_digit : 1'b1;
        endcase

        prod_first  = weight_first(cur.pos) * d;
        prod_second = weight_second(cur.pos) * d;
        tot_first   = {4'd0, cur.first_sum} + prod_first;
        tot_second  = {4'd0, cur.second_sum} + prod_second;

        upd           = cur;
        upd.layout_ok = cur.layout_ok & fits;
        if (in_range)
        begin
            upd.second_sum = mod11(tot_second[6:0]);
            if (cur.pos == POS_CHECK1)
            begin
                // first sum is finished here; from now on it holds the given digit
                upd.first_check = check_value(cur.first_sum);
                upd.first_sum   = d;
            end
            else
            begin
                upd.first_sum = mod11(tot_first[6:0]);
            end
        end
        if (cur.pos != POS_MAX)
            upd.pos = cur.pos + 4'd1;

        if (cur.pos != POS_LAST)
            err = ERR_LENGTH;
        else if (!upd.layout_ok)
            err = ERR_LAYOUT;
        else if (upd.first_check != upd.first_sum || check_value(upd.second_sum) != d)
            err = ERR_CHECK;
        else
            err = ERR_NONE;

        verdict.cpf_valid  = (err == ERR_NONE);
        verdict.error_kind = err;
        nxt                = last_char ? STATE_RESET : upd;
    end

endmodule

`default_nettype wire

### design/cpf_check_digit_validator.sv
`timescale 1ns / 1ps
`default_nettype none

// cpf text checker, mod-11 check digits
// chars: one character a word (char_code, last_char); the text must read
//   ddd.ddd.ddd-dd, and last_char marks its final character
// verdicts: one word per text, issued for the word that carries last_char;
//   cpf_valid is 1 when error_kind is 0 (none), otherwise error_kind gives
//   wrong length, bad layout or check digit mismatch, in that priority
// path: a taken character is held in char_reg; its step result goes into
//   state_reg and, for a last character, into the verdict register
// throughput: one character every cycle while chars.ready stays high; the
//   position, layout flag and the two mod-11 sums update together
// stall: a held verdict stays in the output register; one more text can run
//   up to its last character, and chars.ready drops only while a finished
//   verdict waits behind a stalled one
// reset: clears both valid flags and the text state, returning to the start
//   of a text; a last character also returns the block to the start

module cpf_check_digit_validator
    import cpf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cpf_char_if.sink      chars,
    cpf_verdict_if.source verdicts
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   char_reg;
    logic         last_reg;
    cpf_state_t   state_reg;
    cpf_state_t   state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    cpf_verdict_t verdict_reg;
    cpf_verdict_t verdict_step;
    logic         advance;
    logic         take;

    cpf_step u_step (
        .cur       (state_reg),
        .char_code (char_reg),
        .last_char (last_reg),
        .nxt       (state_next),
        .verdict   (verdict_step)
    );

    // a word without last_char never needs the output register
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || verdicts.ready);
    assign take    = chars.valid && chars.ready;

    assign chars.ready         = !in_valid_reg || advance;
    assign verdicts.valid      = out_valid_reg;
    assign verdicts.cpf_valid  = verdict_reg.cpf_valid;
    assign verdicts.error_kind = verdict_reg.error_kind;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (verdicts.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.last_char;
        end
        if (advance && last_reg)
            verdict_reg <= verdict_step;
    end

endmodule

`default_nettype wire

### design/cpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cpf_check_digit_validator_macros.svh"

module cpf_checker
    import cpf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       cpf_valid,
    input wire logic [1:0] error_kind
);

    // verdict flag and error code must agree
    `CPF_ASSERT_NOW(a_valid_matches_code, clk, rst_n, out_valid, cpf_valid == (error_kind == ERR_NONE))

    // the input side only backs up behind a stalled verdict
    `CPF_ASSERT_NOW(a_ready_only_blocked_by_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

    // a stalled verdict word holds
    `CPF_ASSERT_NEXT(a_verdict_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cpf_valid) && $stable(error_kind))

    // an input word cannot wait while the block is fully drained
    `CPF_ASSERT_NOW(a_ready_when_empty, clk, rst_n, in_valid && !out_valid, in_ready)

endmodule

bind cpf_check_digit_validator cpf_checker u_cpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .out_valid  (verdicts.valid),
    .out_ready  (verdicts.ready),
    .cpf_valid  (verdicts.cpf_valid),
    .error_kind (verdicts.error_kind)
);

`default_nettype wire

### verif/tb_cpf_check_digit_validator.sv
`timescale 1ns / 1ps

module tb_cpf_check_digit_validator;
    import cpf_pkg::*;

    localparam int TEXT_CHARS   = 14;
    localparam int CHAR_TARGET  = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SHOWN_ERRORS = 40;

    // kinds of generated text
    typedef enum int {
        TXT_GOOD,
        TXT_BAD_CHECK,
        TXT_BAD_LAYOUT,
        TXT_BAD_LENGTH,
        TXT_NOISE
    } text_kind_t;

    class cpf_scoreboard;
        cpf_verdict_t expected_verdicts[$];
        logic [3:0]   pos;
        logic         layout_good;
        logic [8:0]   sum_first;
        logic [9:0]   sum_second;
        logic [3:0]   first_check;
        int           errors;
        int           tally[4];

        function new();
            clear();
            errors = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void clear();
            pos         = 4'd0;
            layout_good = 1'b1;
            sum_first   = 9'd0;
            sum_second  = 10'd0;
            first_check = 4'd0;
        endfunction

        static function logic [3:0] check_of(int unsigned s);
            int unsigned r;
            r = (s * 10) % 11;
            return (r == 10) ? 4'd0 : r[3:0];
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void note_char(logic [7:0] c, bit last);
            logic         is_digit;
            logic         fits;
            logic [3:0]   d;
            logic [3:0]   p;
            logic [3:0]   k;
            logic [3:0]   wa;
            logic [3:0]   wb;
            logic [1:0]   err;
            cpf_verdict_t v;
            p = pos;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            d = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
            if (p == POS_DOT1 || p == POS_DOT2)
                fits = (c == CHAR_DOT);
            else if (p == POS_DASH)
                fits = (c == CHAR_DASH);
            else if (p <= POS_LAST)
                fits = is_digit;
            else
                fits = 1'b1;
            if (!fits)
                layout_good = 1'b0;
            if (p <= POS_LAST)
            begin
                // digit slots k = 0..8 skip the separators; weights 10-k and 11-k
                if (p == POS_DOT1 || p == POS_DOT2 || p == POS_DASH || p == POS_LAST)
                begin
                    wa = 4'd0;
                    wb = 4'd0;
                end
                else if (p == POS_CHECK1)
                begin
                    wa = 4'd0;
                    wb = 4'd2;
                end
                else
                begin
                    k  = p - (p >> 2);
                    wa = 4'd10 - k;
                    wb = 4'd11 - k;
                end
                sum_first  = 9'(sum_first + wa * d);
                sum_second = 10'(sum_second + wb * d);
                if (p == POS_CHECK1)
                begin
                    first_check = check_of(32'(sum_first));
                    sum_first   = 9'(d);
                end
            end
            if (pos != POS_MAX)
                pos = pos + 4'd1;
            if (last)
            begin
                if (p != POS_LAST)
                    err = ERR_LENGTH;
                else if (!layout_good)
                    err = ERR_LAYOUT;
                else if (first_check != sum_first || check_of(32'(sum_second)) != d)
                    err = ERR_CHECK;
                else
                    err = ERR_NONE;
                v.cpf_valid  = (err == ERR_NONE);
                v.error_kind = err;
                expected_verdicts.push_back(v);
                clear();
            end
        endfunction

        task report(string what);
            if (errors < SHOWN_ERRORS)
                $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_verdict(logic cv, logic [1:0] ek);
            cpf_verdict_t e;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("verdict with nothing pending, valid=%0b kind=%0d", cv, ek));
                return;
            end
            e = expected_verdicts.pop_front();
            tally[e.error_kind]++;
            if (cv !== e.cpf_valid)
                report($sformatf("cpf_valid %0b, want %0b", cv, e.cpf_valid));
            if (ek !== e.error_kind)
                report($sformatf("error_kind %0d, want %0d", ek, e.error_kind));
        endtask
    endclass

    logic clk;
    logic rst_n;

    cpf_char_if    chars_if ();
    cpf_verdict_if verdicts_if ();

    cpf_check_digit_validator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars_if),
        .verdicts (verdicts_if)
    );

    cpf_scoreboard sb;
    byte unsigned  text_buf[$];
    bit            calm;
    bit            hold_req;
    int            char_total;
    int            text_total;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("[cpf_check_digit_validator] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task send_char(byte unsigned c, bit last);
        int gap;
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        chars_if.last_char <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        sb.note_char(c, last);
        char_total++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task send_text();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_total++;
    endtask

    task drain();
        int waited;
        waited = 0;
        chars_if.valid <= 1'b0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task load_string(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // well-formed layout, check digits right or random
    task make_cpf(bit right_checks);
        int unsigned dg[11];
        int unsigned s1;
        int unsigned s2;
        int          k;
        s1 = 0;
        s2 = 0;
        dg[0] = $urandom_range(0, 9);
        for (int i = 1; i < 9; i++)
            dg[i] = ($urandom_range(0, 9) == 0) ? dg[0] : $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0)
            foreach (dg[i]) dg[i] = dg[0];
        for (int i = 0; i < 9; i++)
            s1 += (10 - i) * dg[i];
        dg[9] = 32'(cpf_scoreboard::check_of(s1));
        for (int i = 0; i < 10; i++)
            s2 += (11 - i) * dg[i];
        dg[10] = 32'(cpf_scoreboard::check_of(s2));
        if (!right_checks)
        begin
            dg[9]  = $urandom_range(0, 9);
            dg[10] = $urandom_range(0, 9);
        end
        text_buf.delete();
        k = 0;
        for (int i = 0; i < TEXT_CHARS; i++)
        begin
            if (i == POS_DOT1 || i == POS_DOT2)
                text_buf.push_back(CHAR_DOT);
            else if (i == POS_DASH)
                text_buf.push_back(CHAR_DASH);
            else
            begin
                text_buf.push_back(8'(CHAR_ZERO + dg[k]));
                k++;
            end
        end
    endtask

    task build_text();
        int r;
        int len;
        int spot;
        text_kind_t kind;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = TXT_GOOD;
        else if (r < 60)
            kind = TXT_BAD_CHECK;
        else if (r < 75)
            kind = TXT_BAD_LAYOUT;
        else if (r < 90)
            kind = TXT_BAD_LENGTH;
        else
            kind = TXT_NOISE;
        case (kind)
            TXT_GOOD:       make_cpf(1'b1);
            TXT_BAD_CHECK:  make_cpf(1'b0);
            TXT_BAD_LAYOUT:
            begin
                make_cpf(1'($urandom_range(0, 1)));
                spot = $urandom_range(0, TEXT_CHARS - 1);
                text_buf[spot] = 8'($urandom_range(0, 255));
            end
            TXT_BAD_LENGTH:
            begin
                make_cpf(1'($urandom_range(0, 1)));
                do
                    len = $urandom_range(1, 24);
                while (len == TEXT_CHARS);
                while (text_buf.size() > len)
                    void'(text_buf.pop_back());
                // past the end mostly digits, some arbitrary bytes
                while (text_buf.size() < len)
                    text_buf.push_back(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                                    : CHAR_ZERO + $urandom_range(0, 9)));
            end
            default:
            begin
                text_buf.delete();
                len = $urandom_range(1, 20);
                repeat (len) text_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // verdict side: random stalls plus one long hold-off on request
    initial
    begin : verdict_sink
        int stall_left;
        stall_left = 0;
        verdicts_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (verdicts_if.valid && verdicts_if.ready)
                sb.check_verdict(verdicts_if.cpf_valid, verdicts_if.error_kind);
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                verdicts_if.ready <= 1'b0;
                stall_left--;
            end
            else
                verdicts_if.ready <= 1'b1;
        end
    end

    initial
    begin
        sb         = new();
        calm       = 1'b0;
        hold_req   = 1'b0;
        char_total = 0;
        text_total = 0;
        rst_n      = 1'b0;
        chars_if.valid     <= 1'b0;
        chars_if.char_code <= 8'd0;
        chars_if.last_char <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // a correct number, all nines (largest sums), then one-character texts
        load_string("111.444.777-35");
        send_text();
        load_string("999.999.999-99");
        send_text();
        text_buf = '{8'h00};
        send_text();
        text_buf = '{8'hFF};
        send_text();
        drain();

        while (char_total < CHAR_TARGET)
        begin
            if (text_total == 30)
                hold_req = 1'b1;
            calm = (text_total >= 30 && text_total < 34) || (text_total % 9 == 0);
            if (text_total == 60)
                drain();
            build_text();
            send_text();
        end
        calm = 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (sb.pending() > 0)
            sb.report($sformatf("%0d verdicts never came", sb.pending()));

        $display("ran %0d texts, %0d characters, incl. a %0d-cycle output hold-off",
                 text_total, char_total, HOLD_CYCLES);
        $display("verdicts seen: %0d valid, %0d length, %0d layout, %0d check digit",
                 sb.tally[ERR_NONE], sb.tally[ERR_LENGTH], sb.tally[ERR_LAYOUT],
                 sb.tally[ERR_CHECK]);
        if (sb.errors == 0)
            $display("[cpf_check_digit_validator] OK");
        else
            $display("[cpf_check_digit_validator] ERROR");
        $finish;
    end

endmodule
